@@ src/flpte_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and sizes for the four-level page table engine.
package flpte_pkg;

  // Table store geometry
  localparam int TABLE_FRAMES = 16;
  localparam int IDX_W        = 9;
  localparam int FRAME_W      = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
  localparam int CNT_W        = $clog2(TABLE_FRAMES + 1);
  localparam int ADDR_W       = FRAME_W + IDX_W;
  localparam int STORE_DEPTH  = TABLE_FRAMES * (1 << IDX_W);

  // Field widths
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int FLAGS_W = 12;
  localparam int ENTRY_W = 64;
  localparam int PFN_W   = PA_W - 12;
  localparam int IN_W    = 120;
  localparam int OUT_W   = 56;

  // Entry flag bits
  localparam int BIT_PRESENT = 0;
  localparam int BIT_USER    = 2;

  // Walk level of the leaf table (levels 0..2 are PML4, PDPT, PD)
  localparam logic [1:0] LVL_LEAF = 2'd3;

  typedef enum logic [1:0] {
    REQ_MAP   = 2'd0,
    REQ_UNMAP = 2'd1,
    REQ_XLATE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_NO_FRAMES  = 2'd2,
    ST_RSVD       = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,   // zero one entry of the frame being swept
    WR_LINK,    // point a table entry at the newly allocated frame
    WR_LEAF,    // write the leaf entry for a map
    WR_UNLEAF   // clear the leaf entry for an unmap
  } wr_op_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FILL,
    S_LINK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       load_req;
    logic       mem_rd;
    wr_op_t     wr_op;
    logic       follow;
    logic       alloc;
    logic [1:0] level;
    logic       finish;
    status_t    status;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic entry_present;
    logic frame_ok;
    logic frames_left;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ src/four_level_page_table_engine.sv @@
`timescale 1ns / 1ps
// Top level of the four-level page table engine: controller plus datapath.
//
// Channel  Dir  Width  Content
// in_*     in   120    one request transfer: type, virtual addr, physical addr, flags
// out_*    out  56     one result transfer per request: physical addr, status
//
// Steps: each table level is read (S_READ) and its entry checked (S_EVAL); at the
//   leaf a map or unmap writes the entry in S_READ instead; S_DONE reports and the
//   walk returns to S_IDLE; the unused type goes from S_READ straight to S_DONE. Each
//   table created by a map adds a 512-entry clear plus the link write, set by the
//   single write port of the table store clearing the new frame.
// Reset: after rst_n the root frame is cleared in one pass, one entry
//   per cycle; in_tready stays low until it is done.
// Stalls: a finished result sits in the output register, so the next request
//   is taken while out_tready is low; it waits only to hand its own result over.
module four_level_page_table_engine
  import flpte_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // Request channel
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // [1:0] req_type, [49:2] virt_addr,
                                        // [101:50] phys_addr, [113:102] page_flags
  // Result channel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // [51:0] result_addr, [53:52] status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: walk levels, allocate and sweep frames, issue the result
  flpte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table store, frame allocator and output register
  flpte_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ src/flpte_dp.sv @@
`timescale 1ns / 1ps
// Datapath: request registers, table store, frame counter, sweep counter, output register.
module flpte_dp
  import flpte_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  logic [ENTRY_W-1:0] store [0:STORE_DEPTH-1];

  req_t               req_r;
  logic [VA_W-1:0]    va_r;
  logic [PA_W-1:0]    pa_r;
  logic [FLAGS_W-1:0] flags_r;
  logic [FRAME_W-1:0] frame_r;
  logic [FRAME_W-1:0] nf_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   sweep_r;
  logic [ENTRY_W-1:0] rdata_r;
  logic               out_valid_r;
  logic [PA_W-1:0]    out_addr_r;
  status_t            out_status_r;

  logic [IDX_W-1:0]   idx;
  logic [ADDR_W-1:0]  walk_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               wr_en;
  logic [PA_W-1:0]    xlate_addr;

  always_comb begin
    case (cmd.level)
      2'd0:    idx = va_r[47:39];
      2'd1:    idx = va_r[38:30];
      2'd2:    idx = va_r[29:21];
      default: idx = va_r[20:12];
    endcase
  end

  assign walk_addr = {frame_r, idx};

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = walk_addr;
    wr_data = '0;
    case (cmd.wr_op)
      WR_CLEAR: begin
        wr_addr = {nf_r, sweep_r};
      end
      WR_LINK: begin
        wr_data = {12'd0, PFN_W'(nf_r), 9'd0, flags_r[BIT_USER], 2'b11};
      end
      WR_LEAF: begin
        wr_data = {12'd0, pa_r[PA_W-1:12], flags_r | 12'h001};
      end
      WR_UNLEAF: begin
        wr_data = '0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rdata_r <= store[walk_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r   <= req_t'(in_tdata[1:0]);
      va_r    <= in_tdata[49:2];
      pa_r    <= in_tdata[101:50];
      flags_r <= in_tdata[113:102];
    end
  end

  // Control state: current frame, allocator, sweep position, output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r     <= '0;
      nf_r        <= '0;
      cnt_r       <= CNT_W'(1);
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        frame_r <= '0;
      end else if (cmd.follow) begin
        frame_r <= rdata_r[12 +: FRAME_W];
      end else if (cmd.wr_op == WR_LINK) begin
        frame_r <= nf_r;
      end
      if (cmd.alloc) begin
        nf_r  <= cnt_r[FRAME_W-1:0];
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.wr_op == WR_CLEAR) begin
        sweep_r <= sweep_r + IDX_W'(1);
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign xlate_addr = {rdata_r[PA_W-1:12], va_r[11:0]};

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= cmd.status;
      out_addr_r   <= (req_r == REQ_XLATE && cmd.status == ST_OK) ? xlate_addr : '0;
    end
  end

  assign sts.req           = req_r;
  assign sts.entry_present = rdata_r[BIT_PRESENT];
  assign sts.frame_ok      = rdata_r[PA_W-1:12] < PFN_W'(TABLE_FRAMES);
  assign sts.frames_left   = cnt_r < CNT_W'(TABLE_FRAMES);
  assign sts.sweep_last    = &sweep_r;
  assign sts.out_free      = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_status_r, out_addr_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_FRAMES))
    else $error("frame counter passed the store size");

  a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |=> cnt_r == $past(cnt_r) + CNT_W'(1) && nf_r == $past(cnt_r[FRAME_W-1:0]))
    else $error("allocation did not bump the frame counter");

  a_link_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_op == WR_LINK |-> CNT_W'(nf_r) < cnt_r)
    else $error("link written to a frame not yet handed out");

endmodule

@@ src/flpte_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences the walk, frame allocation sweeps and result hand-off.
module flpte_ctrl
  import flpte_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] level_r, level_nxt;
  status_t    status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      level_r  <= '0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      level_r  <= level_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    level_nxt    = level_r;
    status_nxt   = status_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.wr_op    = WR_NONE;
    cmd.level    = level_r;
    cmd.status   = status_r;
    case (state_r)
      S_INIT: begin
        cmd.wr_op = WR_CLEAR;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          level_nxt    = '0;
          status_nxt   = ST_OK;
          state_nxt    = S_READ;
        end
      end
      S_READ: begin
        if (sts.req == REQ_NONE) begin
          state_nxt = S_DONE;
        end else if (level_r == LVL_LEAF && sts.req == REQ_MAP) begin
          cmd.wr_op = WR_LEAF;
          state_nxt = S_DONE;
        end else if (level_r == LVL_LEAF && sts.req == REQ_UNMAP) begin
          cmd.wr_op = WR_UNLEAF;
          state_nxt = S_DONE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (level_r == LVL_LEAF) begin
          status_nxt = sts.entry_present ? ST_OK : ST_NOT_MAPPED;
          state_nxt  = S_DONE;
        end else if (sts.entry_present) begin
          if (sts.frame_ok) begin
            cmd.follow = 1'b1;
            level_nxt  = level_r + 2'd1;
            state_nxt  = S_READ;
          end else begin
            status_nxt = ST_NOT_MAPPED;
            state_nxt  = S_DONE;
          end
        end else if (sts.req == REQ_MAP) begin
          if (sts.frames_left) begin
            cmd.alloc = 1'b1;
            state_nxt = S_FILL;
          end else begin
            status_nxt = ST_NO_FRAMES;
            state_nxt  = S_DONE;
          end
        end else begin
          status_nxt = ST_NOT_MAPPED;
          state_nxt  = S_DONE;
        end
      end
      S_FILL: begin
        cmd.wr_op = WR_CLEAR;
        if (sts.sweep_last) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        cmd.wr_op = WR_LINK;
        level_nxt = level_r + 2'd1;
        state_nxt = S_READ;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL |-> $past(state_r) == S_READ)
    else $error("entry evaluated without a preceding read");

  a_fill_to_link: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL && sts.sweep_last |=> state_r == S_LINK)
    else $error("new frame sweep did not end in a link write");

  a_leaf_only_map: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_op == WR_LEAF |-> level_r == LVL_LEAF && sts.req == REQ_MAP)
    else $error("leaf written outside a map at the leaf level");

endmodule
